### sv/ipv6nbt_pkg.sv
// ----------------------------------------------------------------------------
// ipv6nbt_pkg
// Shared sizes, operation codes and types of the IPv6 neighbor bridge table.
// ----------------------------------------------------------------------------
package ipv6nbt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 64;
    localparam int OUT_IDX_W   = 4;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] high;
        logic [ADDR_W-1:0] low;
    } t_entry;

    typedef struct packed {
        logic             clr;
        logic             valid;
        logic             occupied;
        logic             reach;
        logic [IDX_W-1:0] idx;
    } t_scan_ctl;

    typedef struct packed {
        logic             match_now;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             hit_reach;
        logic             vic_found;
        logic [IDX_W-1:0] vic_idx;
    } t_scan_sts;

    function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W+OUT_IDX_W-1:0] ext;
        ext = {{OUT_IDX_W{1'b0}}, idx};
        return ext[OUT_IDX_W-1:0];
    endfunction

endpackage

### sv/ipv6nbt_addr_mem.sv
// ----------------------------------------------------------------------------
// ipv6nbt_addr_mem
// Address store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ipv6nbt_addr_mem (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [ipv6nbt_pkg::IDX_W-1:0] i_wr_addr,
    input  ipv6nbt_pkg::t_entry        i_wr_data,
    input  logic                       i_rd_en,
    input  logic [ipv6nbt_pkg::IDX_W-1:0] i_rd_addr,
    output ipv6nbt_pkg::t_entry        o_rd_data
);
    import ipv6nbt_pkg::*;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/ipv6nbt_scan.sv
// ----------------------------------------------------------------------------
// ipv6nbt_scan
// Shared 128-bit compare unit with first-match and first-victim tracking.
// ----------------------------------------------------------------------------
module ipv6nbt_scan (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ipv6nbt_pkg::t_scan_ctl i_ctl,
    input  ipv6nbt_pkg::t_entry    i_key,
    input  ipv6nbt_pkg::t_entry    i_rd_data,
    output ipv6nbt_pkg::t_scan_sts o_sts
);
    import ipv6nbt_pkg::*;

    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic             r_hit_reach;
    logic             r_vic_found;
    logic [IDX_W-1:0] r_vic_idx;
    logic             w_match;

    assign w_match = i_ctl.valid && i_ctl.occupied && (i_rd_data == i_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_hit       <= 1'b0;
            r_vic_found <= 1'b0;
        end else if (i_ctl.valid) begin
            if (w_match && !r_hit) begin
                r_hit       <= 1'b1;
                r_hit_idx   <= i_ctl.idx;
                r_hit_reach <= i_ctl.reach;
            end
            if (!i_ctl.reach && !r_vic_found) begin
                r_vic_found <= 1'b1;
                r_vic_idx   <= i_ctl.idx;
            end
        end
    end

    assign o_sts.match_now = w_match;
    assign o_sts.hit       = r_hit;
    assign o_sts.hit_idx   = r_hit_idx;
    assign o_sts.hit_reach = r_hit_reach;
    assign o_sts.vic_found = r_vic_found;
    assign o_sts.vic_idx   = r_vic_idx;

endmodule

### sv/ipv6_neighbor_bridge_table.sv
// ----------------------------------------------------------------------------
// ipv6_neighbor_bridge_table
// Neighbor address cache with lookup, add/refresh and delete.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low.
// busy then stays high through the scan and the finish state. The scan first
// issues the read of entry 0; then one compare unit checks one entry per
// cycle through the single read port of the address store. The finish state
// writes back. The result beat is on the o_ ports for one cycle, marked by
// o_valid, in the first cycle that busy is low. That cycle can also take the
// next request. The result beat cannot be held off, so it must be taken when
// shown. The table is empty after reset.
module ipv6_neighbor_bridge_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_op,
    input  logic [ipv6nbt_pkg::ADDR_W-1:0] i_addr_high,
    input  logic [ipv6nbt_pkg::ADDR_W-1:0] i_addr_low,
    output logic                          o_valid,
    output logic                          o_found,
    output logic [ipv6nbt_pkg::OUT_IDX_W-1:0] o_entry_index,
    output logic                          o_entry_reachable,
    output logic                          o_stored_new,
    output logic                          o_table_full
);
    import ipv6nbt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state            r_state;
    logic [1:0]        r_op;
    t_entry            r_key;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_used;
    logic [TABLE_DEPTH-1:0] r_reach;

    logic              r_valid;
    logic              r_found;
    logic [OUT_IDX_W-1:0] r_entry_index;
    logic              r_entry_reachable;
    logic              r_stored_new;
    logic              r_table_full;

    logic [CNT_W-1:0]  w_cnt_m1;
    logic [IDX_W-1:0]  w_cmp_idx;
    logic              w_scan_last;
    logic              w_room;
    logic              w_wr_en;
    logic [IDX_W-1:0]  w_wr_addr;
    t_scan_ctl         w_ctl;
    t_scan_sts         w_sts;
    t_entry            w_rd_data;

    assign w_cnt_m1    = r_cnt - CNT_W'(1);
    assign w_cmp_idx   = w_cnt_m1[IDX_W-1:0];
    assign w_scan_last = (r_cnt == CNT_W'(TABLE_DEPTH));
    assign w_room      = (r_used < CNT_W'(TABLE_DEPTH));

    assign w_ctl.clr      = (r_state == S_IDLE);
    assign w_ctl.valid    = (r_state == S_SCAN) && (r_cnt != '0);
    assign w_ctl.occupied = (w_cnt_m1 < r_used);
    assign w_ctl.reach    = r_reach[w_cmp_idx];
    assign w_ctl.idx      = w_cmp_idx;

    // write back a new or replaced entry
    assign w_wr_en   = (r_state == S_FINISH) && (r_op == OP_ADD) && !w_sts.hit
                       && (w_room || w_sts.vic_found);
    assign w_wr_addr = w_room ? r_used[IDX_W-1:0] : w_sts.vic_idx;

    ipv6nbt_addr_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (r_key),
        .i_rd_en   ((r_state == S_SCAN) && !w_scan_last),
        .i_rd_addr (r_cnt[IDX_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    ipv6nbt_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_key     (r_key),
        .i_rd_data (w_rd_data),
        .o_sts     (w_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_used  <= '0;
            r_reach <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op      <= i_op;
                        r_key     <= '{high: i_addr_high, low: i_addr_low};
                        r_cnt     <= '0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if ((r_op == OP_DELETE) && w_sts.match_now) begin
                        r_reach[w_cmp_idx] <= 1'b0;
                    end
                    if (w_scan_last) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_FINISH: begin
                    r_valid           <= 1'b1;
                    r_found           <= w_sts.hit;
                    r_entry_reachable <= w_sts.hit && w_sts.hit_reach;
                    r_entry_index     <= w_sts.hit ? to_out_idx(w_sts.hit_idx) : '0;
                    r_stored_new      <= 1'b0;
                    r_table_full      <= 1'b0;
                    if (r_op == OP_ADD) begin
                        if (w_sts.hit) begin
                            r_reach[w_sts.hit_idx] <= 1'b1;
                        end else if (w_room || w_sts.vic_found) begin
                            r_reach[w_wr_addr] <= 1'b1;
                            r_entry_index      <= to_out_idx(w_wr_addr);
                            r_stored_new       <= 1'b1;
                            if (w_room) begin
                                r_used <= r_used + CNT_W'(1);
                            end
                        end else begin
                            r_table_full <= 1'b1;
                        end
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_valid;
    assign o_found           = r_found;
    assign o_entry_index     = r_entry_index;
    assign o_entry_reachable = r_entry_reachable;
    assign o_stored_new      = r_stored_new;
    assign o_table_full      = r_table_full;

    a_finish_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) |=> o_valid)
        else $error("finish cycle gave no result beat");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_new_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stored_new) |-> (!o_found && !o_table_full))
        else $error("new entry stored for a present address or a dropped add");

    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |-> (!o_found && (o_entry_index == '0)
                                       && (r_used == CNT_W'(TABLE_DEPTH))))
        else $error("dropped add with room or a match");

    a_busy_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !o_valid || (r_cnt == '0))
        else $error("result beat during scan");

endmodule

### tb/ipv6_neighbor_bridge_table_tb.sv
// ----------------------------------------------------------------------------
// ipv6_neighbor_bridge_table_tb
// Self-checking bench for the neighbor cache: a directed table walks empty,
// refresh, delete, fill, drop and victim replacement, then random requests
// over a small address pool keep the cache full and churning. Every result
// beat is checked against its row's fixed values or a cycle-free bench model.
// ----------------------------------------------------------------------------
module ipv6_neighbor_bridge_table_tb;

    import ipv6nbt_pkg::*;

    localparam logic [1:0] OP_RESERVED  = 2'd3;
    localparam int         RANDOM_COUNT = 450;
    localparam int         POOL_SIZE    = 24;
    localparam int         QUIET_LIMIT  = 1000;
    localparam logic [63:0] ALL_ONES    = '1;

    typedef struct packed {
        logic                 found;
        logic [OUT_IDX_W-1:0] index;
        logic                 reach;
        logic                 stored;
        logic                 full;
    } t_nb_result;

    typedef struct {
        logic [1:0]  op;
        logic [63:0] high;
        logic [63:0] low;
        bit          known;
        t_nb_result  outcome;
    } t_nb_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           i_op = OP_LOOKUP;
    logic [ADDR_W-1:0]    i_addr_high = '0;
    logic [ADDR_W-1:0]    i_addr_low = '0;
    logic                 o_valid;
    logic                 o_found;
    logic [OUT_IDX_W-1:0] o_entry_index;
    logic                 o_entry_reachable;
    logic                 o_stored_new;
    logic                 o_table_full;

    logic [63:0] cache_high [TABLE_DEPTH];
    logic [63:0] cache_low [TABLE_DEPTH];
    bit          cache_reach [TABLE_DEPTH];
    int          cache_used = 0;

    t_nb_result  pending_results [$];
    t_nb_row     directed_rows [$];
    logic [63:0] pool_high [POOL_SIZE];
    logic [63:0] pool_low [POOL_SIZE];
    int          mismatches = 0;
    int unsigned quiet_cycles = 0;
    bit          gaps_on = 1'b1;

    ipv6_neighbor_bridge_table dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_op              (i_op),
        .i_addr_high       (i_addr_high),
        .i_addr_low        (i_addr_low),
        .o_valid           (o_valid),
        .o_found           (o_found),
        .o_entry_index     (o_entry_index),
        .o_entry_reachable (o_entry_reachable),
        .o_stored_new      (o_stored_new),
        .o_table_full      (o_table_full)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_nb_result resolve_neighbor(input logic [1:0] op,
                                                    input logic [63:0] hi,
                                                    input logic [63:0] lo);
        t_nb_result r;
        int         hit;
        int         slot;
        bit         have;
        r    = '0;
        hit  = -1;
        slot = 0;
        have = 1'b0;
        for (int k = 0; k < cache_used; k++) begin
            if (hit < 0 && cache_high[k] == hi && cache_low[k] == lo) hit = k;
        end
        if (hit >= 0) begin
            r.found = 1'b1;
            r.index = OUT_IDX_W'(hit);
            r.reach = cache_reach[hit];
        end
        if (op == OP_ADD) begin
            if (hit >= 0) begin
                cache_reach[hit] = 1'b1;
            end else begin
                if (cache_used < TABLE_DEPTH) begin
                    slot = cache_used;
                    cache_used++;
                    have = 1'b1;
                end else begin
                    for (int k = 0; k < TABLE_DEPTH; k++) begin
                        if (!have && !cache_reach[k]) begin
                            slot = k;
                            have = 1'b1;
                        end
                    end
                end
                if (have) begin
                    cache_high[slot]  = hi;
                    cache_low[slot]   = lo;
                    cache_reach[slot] = 1'b1;
                    r.index  = OUT_IDX_W'(slot);
                    r.stored = 1'b1;
                end else begin
                    r.full = 1'b1;
                end
            end
        end else if (op == OP_DELETE) begin
            for (int k = 0; k < cache_used; k++) begin
                if (cache_high[k] == hi && cache_low[k] == lo) cache_reach[k] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic void add_row(input logic [1:0] op, input logic [63:0] hi,
                                    input logic [63:0] lo, input bit known,
                                    input logic f, input int idx, input logic rch,
                                    input logic st, input logic fl);
        t_nb_row row;
        row.op      = op;
        row.high    = hi;
        row.low     = lo;
        row.known   = known;
        row.outcome = '{f, OUT_IDX_W'(idx), rch, st, fl};
        directed_rows.push_back(row);
    endfunction

    task automatic send_request(input logic [1:0] op, input logic [63:0] hi,
                                input logic [63:0] lo, input bit known,
                                input t_nb_result typed);
        t_nb_result predicted;
        while (gaps_on && $urandom_range(99) < 21) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_op        <= op;
        i_addr_high <= hi;
        i_addr_low  <= lo;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        predicted = resolve_neighbor(op, hi, lo);
        pending_results.push_back(known ? typed : predicted);
    endtask

    task automatic check_field(input string name, input logic [3:0] want,
                               input logic [3:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // result beat checker
    always @(posedge i_clk) begin
        t_nb_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual found=%0b idx=%0h",
                         $time, o_found, o_entry_index);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("found", 4'(want.found), 4'(o_found));
                check_field("entry_index", want.index, o_entry_index);
                check_field("entry_reachable", 4'(want.reach), 4'(o_entry_reachable));
                check_field("stored_new", 4'(want.stored), 4'(o_stored_new));
                check_field("table_full", 4'(want.full), 4'(o_table_full));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_valid === 1'b1) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [1:0]   op;
        logic [127:0] addr;
        int           pick;
        int           roll;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            cache_high[k]  = '0;
            cache_low[k]   = '0;
            cache_reach[k] = 1'b0;
        end
        for (int k = 0; k < POOL_SIZE; k++) begin
            pool_high[k] = {$urandom, $urandom};
            pool_low[k]  = {$urandom, $urandom};
        end

        // empty table, refresh, delete, reserved op
        add_row(OP_LOOKUP,   '0,       '0,       1'b1, 0, 0, 0, 0, 0);
        add_row(OP_ADD,      '0,       '0,       1'b1, 0, 0, 0, 1, 0);
        add_row(OP_ADD,      ALL_ONES, ALL_ONES, 1'b1, 0, 1, 0, 1, 0);
        add_row(OP_ADD,      '0,       '0,       1'b1, 1, 0, 1, 0, 0);
        add_row(OP_DELETE,   '0,       '0,       1'b1, 1, 0, 1, 0, 0);
        add_row(OP_LOOKUP,   '0,       '0,       1'b1, 1, 0, 0, 0, 0);
        add_row(OP_ADD,      '0,       '0,       1'b1, 1, 0, 0, 0, 0);
        add_row(OP_RESERVED, ALL_ONES, ALL_ONES, 1'b1, 1, 1, 1, 0, 0);
        // fill to capacity
        for (int k = 2; k < TABLE_DEPTH; k++) begin
            add_row(OP_ADD, {32'h0, 32'(k)}, ~64'(k), 1'b1, 0, k, 0, 1, 0);
        end
        // full with no victim, then make one and replace it
        add_row(OP_ADD,    ALL_ONES, '0,       1'b1, 0, 0, 0, 0, 1);
        add_row(OP_DELETE, ALL_ONES, ALL_ONES, 1'b1, 1, 1, 1, 0, 0);
        add_row(OP_ADD,    ALL_ONES, '0,       1'b1, 0, 1, 0, 1, 0);
        add_row(OP_LOOKUP, ALL_ONES, ALL_ONES, 1'b1, 0, 0, 0, 0, 0);
        add_row(OP_LOOKUP, '1 >> 1,  '0,       1'b0, 0, 0, 0, 0, 0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n]) begin
            send_request(directed_rows[n].op, directed_rows[n].high, directed_rows[n].low,
                         directed_rows[n].known, directed_rows[n].outcome);
        end

        for (int n = 0; n < RANDOM_COUNT; n++) begin
            gaps_on = !(n >= 150 && n < 260);
            roll = $urandom_range(99);
            if (roll < 45)      op = OP_ADD;
            else if (roll < 65) op = OP_DELETE;
            else if (roll < 95) op = OP_LOOKUP;
            else                op = OP_RESERVED;
            pick = $urandom_range(POOL_SIZE - 1);
            addr = {pool_high[pick], pool_low[pick]};
            roll = $urandom_range(99);
            if (roll < 8) begin
                addr = {$urandom, $urandom, $urandom, $urandom};
            end else if (roll < 16) begin
                addr[$urandom_range(127)] ^= 1'b1;
            end
            send_request(op, addr[127:64], addr[63:0], 1'b0, '0);
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
sv/ipv6nbt_pkg.sv
sv/ipv6nbt_addr_mem.sv
sv/ipv6nbt_scan.sv
sv/ipv6_neighbor_bridge_table.sv
tb/ipv6_neighbor_bridge_table_tb.sv
